// ===== src/array_list_engine_assert.svh =====
// assertion macros used by the checker file
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// plain property, disabled while reset is high
`define ALE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// overlapping implication, disabled while reset is high
`define ALE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ALE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ale_pkg.sv =====
// package for the array list engine: field widths, command and status codes
`timescale 1ns / 1ps

package ale_pkg;

   localparam int CAPACITY_DEF = 32;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int STATUS_W = 3;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_CREATED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_POS     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd5;

endpackage

// ===== src/array_list_engine.sv =====
// array list engine: ordered list of signed values with append, insert, delete, find, display
`timescale 1ns / 1ps
//
// usage
//   request channel: req_cmd, req_value, req_position, req_start_new are taken
//   at a rising edge with start high and busy low
//   result channel: each result sits on the rsp_ ports for one cycle with
//   rsp_valid high; rsp_last marks the final result of a request
//   the receiver cannot stall, so results are never held back
// latency and throughput
//   create, insert at the end, delete of the top entry, every rejected request
//   and unknown commands: result in the next cycle, busy stays low, so one
//   request per cycle
//   insert inside the list: busy through S_INS (shift up), S_INS_WB, S_INS_FIN
//   (new value in); delete inside the list: busy through S_DEL (shift down) and
//   S_DEL_WB; find: busy until a match or the last entry; display: busy until
//   the last entry; the walk goes one entry per cycle through the single read
//   port of the element memory and separate pointer increment/decrement adders
// reset
//   synchronous; the list is empty and no result is pending, the element
//   memory itself is not cleared and needs no clearing pass
//
module array_list_engine
   import ale_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   input  logic                       req_start_new,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_elem_value,
   output logic [INDEX_W-1:0]         rsp_elem_index,
   output logic [COUNT_W-1:0]         rsp_elem_count,
   output logic                       rsp_last
);

   // address width and count width (count can hold CAPACITY itself)
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_INS     = 8'b0000_0010,  // shift entries up, top down
      S_INS_WB  = 8'b0000_0100,  // write back last shifted entry
      S_INS_FIN = 8'b0000_1000,  // drop new value into the gap
      S_DEL     = 8'b0001_0000,  // shift entries down, bottom up
      S_DEL_WB  = 8'b0010_0000,  // write back last shifted entry
      S_FIND    = 8'b0100_0000,
      S_SHOW    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             ptr_ff, ptr_in;
   logic                      pend_ff, pend_in;      // rdata_ff holds a live read
   logic [AW-1:0]             pend_idx_ff, pend_idx_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]          pos_ff, pos_in;

   // element memory, one write and one registered read port
   logic signed [VALUE_W-1:0] mem_ff [CAPACITY];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   // pointer step logic shared by the walk states, and helpers
   logic [CW-1:0]      ptr_inc, ptr_dec, last_idx, base_cnt;
   logic [COUNT_W-1:0] pos_ext, cnt_ext;
   logic               accept;
   logic               pend_is_last;

   assign accept   = start && (state_ff == S_IDLE);
   assign ptr_inc  = ptr_ff + 1'b1;
   assign ptr_dec  = ptr_ff - 1'b1;
   assign last_idx = count_ff - 1'b1;
   assign pos_ext  = COUNT_W'(req_position);
   assign cnt_ext  = COUNT_W'(count_ff);
   assign pend_is_last = (CW'(pend_idx_ff) == last_idx);
   // start flag of create empties the list before the append
   assign base_cnt = (req_cmd == CMD_CREATE && req_start_new) ? '0 : count_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      value_in    = value_ff;
      pos_in      = pos_ff;

      wr_en   = 1'b0;
      wr_addr = pend_idx_ff;
      wr_data = rdata_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      rsp_index_in  = '0;
      rsp_count_in  = cnt_ext;
      rsp_last_in   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in     = req_value;
               pos_in       = req_position;
               rsp_valid_in = 1'b1;
               case (req_cmd)
                  CMD_CREATE: begin
                     if (base_cnt >= CAP_C) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = base_cnt[AW-1:0];
                        wr_data      = req_value;
                        count_in     = base_cnt + 1'b1;
                        rsp_count_in = COUNT_W'(count_in);
                     end
                  end
                  CMD_INSERT: begin
                     if (count_ff >= CAP_C) begin
                        rsp_status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        rsp_status_in = ST_NOT_CREATED;
                     end else if (pos_ext > cnt_ext) begin
                        rsp_status_in = ST_BAD_POS;
                     end else if (pos_ext == cnt_ext) begin
                        // insert at the end is a plain append
                        wr_en        = 1'b1;
                        wr_addr      = count_ff[AW-1:0];
                        wr_data      = req_value;
                        count_in     = count_ff + 1'b1;
                        rsp_count_in = COUNT_W'(count_in);
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = last_idx;
                        state_in     = S_INS;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        rsp_status_in = ST_BAD_POS;
                     end else if (pos_ext + 1'b1 == cnt_ext) begin
                        // deleting the top entry needs no shift
                        count_in     = last_idx;
                        rsp_count_in = COUNT_W'(last_idx);
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = CW'(pos_ext + 1'b1);
                        state_in     = S_DEL;
                     end
                  end
                  CMD_FIND, CMD_DISPLAY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ptr_in       = '0;
                        state_in     = (req_cmd == CMD_FIND) ? S_FIND : S_SHOW;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_INS: begin
            // read entry ptr, write the previous read one slot higher
            pend_in     = 1'b1;
            pend_idx_in = ptr_ff[AW-1:0];
            ptr_in      = ptr_dec;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff + 1'b1;
            end
            if (COUNT_W'(ptr_ff) == COUNT_W'(pos_ff)) begin
               state_in = S_INS_WB;
            end
         end
         S_INS_WB: begin
            wr_en    = 1'b1;
            wr_addr  = pend_idx_ff + 1'b1;
            state_in = S_INS_FIN;
         end
         S_INS_FIN: begin
            wr_en        = 1'b1;
            wr_addr      = pos_ff[AW-1:0];
            wr_data      = value_ff;
            count_in     = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
            rsp_count_in = COUNT_W'(count_in);
            state_in     = S_IDLE;
         end
         S_DEL: begin
            // read entry ptr, write the previous read one slot lower
            pend_in     = 1'b1;
            pend_idx_in = ptr_ff[AW-1:0];
            ptr_in      = ptr_inc;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - 1'b1;
            end
            if (ptr_inc == count_ff) begin
               state_in = S_DEL_WB;
            end
         end
         S_DEL_WB: begin
            wr_en        = 1'b1;
            wr_addr      = pend_idx_ff - 1'b1;
            count_in     = last_idx;
            rsp_valid_in = 1'b1;
            rsp_count_in = COUNT_W'(last_idx);
            state_in     = S_IDLE;
         end
         S_FIND: begin
            if (ptr_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_inc;
            end
            if (pend_ff) begin
               if (rdata_ff == value_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = rdata_ff;
                  rsp_index_in = INDEX_W'(pend_idx_ff);
                  pend_in      = 1'b0;
                  state_in     = S_IDLE;
               end else if (pend_is_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOT_FOUND;
                  pend_in       = 1'b0;
                  state_in      = S_IDLE;
               end
            end
         end
         S_SHOW: begin
            if (ptr_ff < count_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_inc;
            end
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rdata_ff;
               rsp_index_in = INDEX_W'(pend_idx_ff);
               rsp_last_in  = pend_is_last;
               if (pend_is_last) begin
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pend_idx_ff   <= pend_idx_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // element memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[ptr_ff[AW-1:0]];
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_elem_value = rsp_value_ff;
   assign rsp_elem_index = rsp_index_ff;
   assign rsp_elem_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== src/ale_checker.sv =====
// port-level checker for the array list engine and its bind
`timescale 1ns / 1ps
`include "array_list_engine_assert.svh"

module ale_checker
   import ale_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [CMD_W-1:0]    req_cmd,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [COUNT_W-1:0]  rsp_elem_count,
   input logic                rsp_last
);

   // count never passes the capacity
   `ALE_ASSERT_IMPL(a_count_cap, clock, reset, rsp_valid, rsp_elem_count <= CAPACITY, "count over capacity")

   // create answers in the next cycle and leaves the block free
   `ALE_ASSERT_NEXT(a_create_quick, clock, reset, start && !busy && req_cmd == CMD_CREATE, rsp_valid && rsp_last && !busy, "create did not answer next cycle")

   // display results come back to back until the last one
   `ALE_ASSERT_NEXT(a_run_gapless, clock, reset, rsp_valid && !rsp_last, rsp_valid && rsp_status == ST_OK, "gap in display run")

   // a failure always ends the run
   `ALE_ASSERT_IMPL(a_fail_last, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_last, "failure without last mark")

endmodule

bind array_list_engine ale_checker #(.CAPACITY(CAPACITY)) u_ale_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_elem_count (rsp_elem_count),
   .rsp_last       (rsp_last)
);
